// ===== sv/lenu8_pkg.sv =====
// types, constants and helpers shared by the lenient utf-8 decoder
// no dependencies; imported by the interfaces, the decode core and the top level
`default_nettype none

package lenu8_pkg;

  localparam int CODE_BITS = 32;   // width of the code point kept internally
  localparam int CP_W      = 32;   // width of the code point on the result port

  localparam logic [7:0] ASCII_LIMIT = 8'd128;
  localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
  localparam int         CONT_BITS = 6;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [2:0]           pend_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            terminator;
  } result_t;

  // results produced by one request: count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_res_t;

  // truncate or zero-extend the internal value to the port width
  function automatic logic [CP_W-1:0] cp_trunc(input code_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[CP_W-1:0];
  endfunction

  // number of leading one bits of a byte, 0..8
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lenu8_if.sv =====
// valid/ready channel interfaces for the decoder input bytes and result code points
// depends on lenu8_pkg for the code point width
`default_nettype none

interface lenu8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_text;

  modport source (output valid, output byte_value, output end_of_text, input ready);
  modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

interface lenu8_out_if import lenu8_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            terminator;

  modport source (output valid, output code_point, output terminator, input ready);
  modport sink   (input valid, input code_point, input terminator, output ready);
endinterface

`default_nettype wire

// ===== sv/lenu8_dec.sv =====
// decode core: sequence state and the results of one byte request
// depends on lenu8_pkg
`default_nettype none

module lenu8_dec import lenu8_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] byte_value,
  input  wire logic       end_of_text,
  output dec_res_t        res,
  output logic            pending_zero
);

  pend_t pending_r, pending_nxt;
  code_t partial_r, partial_nxt;

  logic [3:0] n_ones;
  logic [7:0] payload;
  code_t      shifted;
  pend_t      pend_dec;
  result_t    part_res;
  result_t    byte_res;

  always_comb begin
    n_ones   = lead_ones(byte_value);
    payload  = (n_ones >= 4'd8) ? 8'd0 : (byte_value & (PAYLOAD_MASK >> n_ones));
    shifted  = code_t'({partial_r, byte_value[CONT_BITS-1:0]});
    pend_dec = pending_r - 3'd1;

    part_res.code_point = cp_trunc(partial_r);
    part_res.terminator = 1'b0;
    byte_res.code_point = CP_W'(byte_value);
    byte_res.terminator = 1'b0;

    res          = '0;
    pending_nxt  = pending_r;
    partial_nxt  = partial_r;

    if (end_of_text) begin
      // flush a partial value, then the closing zero
      if (pending_r != '0) begin
        res.count  = 2'd2;
        res.first  = part_res;
        res.second = '{code_point: '0, terminator: 1'b1};
      end else begin
        res.count = 2'd1;
        res.first = '{code_point: '0, terminator: 1'b1};
      end
      pending_nxt = '0;
      partial_nxt = '0;
    end else if (byte_value < ASCII_LIMIT) begin
      if (pending_r != '0) begin
        res.count  = 2'd2;
        res.first  = part_res;
        res.second = byte_res;
      end else begin
        res.count = 2'd1;
        res.first = byte_res;
      end
      pending_nxt = '0;
      partial_nxt = '0;
    end else if (pending_r != '0) begin
      // any high byte counts as a continuation here
      pending_nxt = pend_dec;
      if (pend_dec == '0) begin
        res.count            = 2'd1;
        res.first.code_point = cp_trunc(shifted);
        partial_nxt          = '0;
      end else begin
        partial_nxt = shifted;
      end
    end else if (n_ones <= 4'd1) begin
      // lone continuation byte goes out at once
      res.count            = 2'd1;
      res.first.code_point = CP_W'(payload);
    end else begin
      partial_nxt = code_t'(payload);
      pending_nxt = pend_t'(n_ones - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      partial_r <= '0;
    end else if (fire) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

  assign pending_zero = (pending_r == '0);

endmodule

`default_nettype wire

// ===== sv/lenient_utf8_decoder.sv =====
// path: a byte is registered in the input register, decoded from it once the result
// buffer has room, and its first result is shown from the buffer's head entry
// throughput: one byte per cycle while the result buffer has room; a byte with two
// results holds the input while the two-entry result buffer drains
// reset (rst_n low, synchronous) empties the buffers and clears the sequence state
// top level; depends on lenu8_pkg, lenu8_if and lenu8_dec
`default_nettype none

module lenient_utf8_decoder import lenu8_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lenu8_in_if.sink    in_ch,
  lenu8_out_if.source out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  dec_res_t   res;
  logic       pending_zero;
  logic       fire;
  logic       pop;
  logic [1:0] free;
  logic [1:0] rem_cnt;
  logic [1:0] add_cnt;

  result_t    ent0_r, ent0_nxt;
  result_t    ent1_r, ent1_nxt;
  result_t    rem0;
  logic [1:0] count_r, count_nxt;

  lenu8_dec u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .byte_value  (in_byte_r),
    .end_of_text (in_eot_r),
    .res         (res),
    .pending_zero(pending_zero)
  );

  assign pop   = out_ch.valid && out_ch.ready;
  assign free  = 2'd2 - count_r + {1'b0, pop};
  assign fire  = in_valid_r && (res.count <= free);
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.byte_value;
      in_eot_r  <= in_ch.end_of_text;
    end
  end

  // result buffer: entry 0 is the head, new results append behind what remains
  always_comb begin
    rem_cnt   = count_r - {1'b0, pop};
    rem0      = pop ? ent1_r : ent0_r;
    add_cnt   = fire ? res.count : 2'd0;
    count_nxt = rem_cnt + add_cnt;
    ent0_nxt  = ent0_r;
    ent1_nxt  = ent1_r;
    case (rem_cnt)
      2'd0: begin
        ent0_nxt = res.first;
        ent1_nxt = res.second;
      end
      2'd1: begin
        ent0_nxt = rem0;
        ent1_nxt = res.first;
      end
      default: begin
        ent0_nxt = ent0_r;
        ent1_nxt = ent1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign out_ch.valid      = (count_r != 2'd0);
  assign out_ch.code_point = ent0_r.code_point;
  assign out_ch.terminator = ent0_r.terminator;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("result buffer overfilled");

  a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (res.count <= free))
    else $error("decode fired without buffer room");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_eot_r) |=> pending_zero)
    else $error("end marker left a sequence pending");

  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.count == 2'd2) |-> !res.first.terminator)
    else $error("terminator not the last result of a request");

endmodule

`default_nettype wire
